// File: rtl/tiu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trie insert/lookup shared definitions
// default sizes, symbol range, status codes and controller/datapath structs
// ----------------------------------------------------------------------------
package tiu_pkg;

    localparam int NODES_DEF      = 1024;
    localparam int SYMBOLS_DEF    = 75;
    localparam int VALUE_BITS_DEF = 16;

    // symbol range of a key byte
    localparam logic [7:0] FIRST_SYMBOL = 8'd48;
    localparam logic [7:0] LAST_SYMBOL  = 8'd122;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_CHAR  = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic clear;     // clearing pass step
        logic accept;    // take the input word, issue link read
        logic resolve;   // act on the link read
        logic out_load;  // load the result register
        logic out_val;   // result comes from the node value read
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic last;
        logic need_val;
    } t_sts;

endpackage

// File: rtl/tiu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiu simple dual port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module tiu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/tiu_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiu datapath
// walk registers, child link and node value memories, result register
// ----------------------------------------------------------------------------
module tiu_dp #(
    parameter int NODES      = tiu_pkg::NODES_DEF,
    parameter int SYMBOLS    = tiu_pkg::SYMBOLS_DEF,
    parameter int VALUE_BITS = tiu_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tiu_pkg::t_cmd         i_cmd,
    output tiu_pkg::t_sts         o_sts,
    input  logic                  i_mode,
    input  logic [7:0]            i_character,
    input  logic                  i_last,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic [1:0]            o_status,
    output logic [VALUE_BITS-1:0] o_result_value
);

    import tiu_pkg::*;

    localparam int SLOTS  = NODES * SYMBOLS;
    localparam int NODE_W = $clog2(NODES);
    localparam int USED_W = $clog2(NODES + 1);
    localparam int SLOT_W = $clog2(SLOTS);

    // walk state
    logic [NODE_W-1:0]     r_cur;
    t_status               r_fail;
    logic [USED_W-1:0]     r_used;
    logic [SLOT_W-1:0]     r_clr;

    // word held between accept and resolve
    logic                  r_mode;
    logic                  r_last;
    logic                  r_walk;
    logic [VALUE_BITS-1:0] r_value;
    logic [SLOT_W-1:0]     r_slot;

    t_status               r_status;
    logic [VALUE_BITS-1:0] r_rvalue;

    logic [7:0]            sym_full;
    logic                  char_ok;
    logic                  walk_in;
    logic [SLOT_W-1:0]     slot_in;
    t_status               fail_in;

    logic [NODE_W-1:0]     link_rdata;
    logic [VALUE_BITS:0]   node_rdata;
    logic                  link_zero;
    logic                  room;
    logic                  alloc;
    t_status               fail_res;
    logic [NODE_W-1:0]     next_node;
    logic                  ins_store;
    logic                  need_val;

    logic                  link_we;
    logic [SLOT_W-1:0]     link_waddr;
    logic [NODE_W-1:0]     link_wdata;
    logic                  node_we;
    logic [NODE_W-1:0]     node_waddr;
    logic [VALUE_BITS:0]   node_wdata;

    // symbol check and slot address of the incoming word
    assign sym_full = i_character - FIRST_SYMBOL;
    assign char_ok  = (i_character >= FIRST_SYMBOL) && (i_character <= LAST_SYMBOL)
                      && ({1'b0, sym_full} < 9'(SYMBOLS));
    assign walk_in  = (r_fail == ST_OK) && char_ok;
    assign slot_in  = SLOT_W'(r_cur) * SLOT_W'(SYMBOLS) + SLOT_W'(sym_full);
    assign fail_in  = (r_fail != ST_OK) ? r_fail : (char_ok ? ST_OK : ST_BAD_CHAR);

    // link resolution
    assign link_zero = (link_rdata == '0);
    assign room      = (r_used < USED_W'(NODES));
    assign alloc     = r_walk && link_zero && r_mode && room;

    always_comb begin
        fail_res  = r_fail;
        next_node = r_cur;
        if (r_walk) begin
            if (!link_zero) begin
                fail_res  = ST_OK;
                next_node = link_rdata;
            end else if (!r_mode) begin
                fail_res  = ST_NOT_FOUND;
            end else if (!room) begin
                fail_res  = ST_FULL;
            end else begin
                fail_res  = ST_OK;
                next_node = r_used[NODE_W-1:0];
            end
        end
    end

    assign ins_store = r_last && r_mode && (fail_res == ST_OK);
    assign need_val  = r_last && !r_mode && (fail_res == ST_OK);

    // memory ports
    assign link_we    = i_cmd.clear || (i_cmd.resolve && alloc);
    assign link_waddr = i_cmd.clear ? r_clr : r_slot;
    assign link_wdata = i_cmd.clear ? '0 : r_used[NODE_W-1:0];

    assign node_we    = (i_cmd.clear && (r_clr < SLOT_W'(NODES)))
                        || (i_cmd.resolve && (alloc || ins_store));
    assign node_waddr = i_cmd.clear ? r_clr[NODE_W-1:0] : next_node;
    assign node_wdata = (!i_cmd.clear && ins_store) ? {1'b1, r_value} : '0;

    tiu_ram #(
        .WIDTH (NODE_W),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (i_cmd.accept && walk_in),
        .i_raddr (slot_in),
        .o_rdata (link_rdata)
    );

    // node value memory, top bit marks a stored value
    tiu_ram #(
        .WIDTH (VALUE_BITS + 1),
        .DEPTH (NODES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_re    (i_cmd.resolve && need_val),
        .i_raddr (next_node),
        .o_rdata (node_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= '0;
            r_fail <= ST_OK;
            r_used <= USED_W'(1);
            r_clr  <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_clr <= r_clr + SLOT_W'(1);
            end
            if (i_cmd.accept) begin
                r_fail <= fail_in;
            end
            if (i_cmd.resolve) begin
                r_cur  <= r_last ? '0 : next_node;
                r_fail <= r_last ? ST_OK : fail_res;
                if (alloc) begin
                    r_used <= r_used + USED_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode  <= i_mode;
            r_last  <= i_last;
            r_walk  <= walk_in;
            r_value <= i_value;
            r_slot  <= slot_in;
        end
        if (i_cmd.out_load) begin
            if (i_cmd.out_val) begin
                r_status <= node_rdata[VALUE_BITS] ? ST_OK : ST_NOT_FOUND;
                r_rvalue <= node_rdata[VALUE_BITS] ? node_rdata[VALUE_BITS-1:0] : '0;
            end else begin
                r_status <= fail_res;
                r_rvalue <= '0;
            end
        end
    end

    assign o_sts.clear_done = (r_clr == SLOT_W'(SLOTS - 1));
    assign o_sts.last       = r_last;
    assign o_sts.need_val   = need_val;

    assign o_status       = r_status;
    assign o_result_value = r_rvalue;

    property p_used_bound;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(NODES);
    endproperty
    a_used_bound: assert property (p_used_bound)
        else $error("node pool count beyond pool size");

    property p_alloc_only_insert;
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.resolve && alloc) |-> (r_mode && link_zero && r_walk);
    endproperty
    a_alloc_only_insert: assert property (p_alloc_only_insert)
        else $error("node allocated outside an insert with a missing link");

    property p_key_end_clears;
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.resolve && r_last) |=> (r_cur == '0 && r_fail == ST_OK);
    endproperty
    a_key_end_clears: assert property (p_key_end_clears)
        else $error("walk state not cleared at end of key");

endmodule

// File: rtl/tiu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiu controller
// sequences clearing pass, link read, link resolve and value read
// ----------------------------------------------------------------------------
module tiu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_stall,
    input  tiu_pkg::t_sts i_sts,
    output tiu_pkg::t_cmd o_cmd,
    output logic          o_stall,
    output logic          o_valid
);

    import tiu_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_LINK  = 4'b0100,
        S_VAL   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_o_valid, n_o_valid;
    logic   out_free;
    t_cmd   cmd;

    assign out_free = !r_o_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = S_LINK;
                end
            end
            S_LINK: begin
                if (!i_sts.last || i_sts.need_val || out_free) begin
                    cmd.resolve = 1'b1;
                    if (i_sts.need_val) begin
                        n_state = S_VAL;
                    end else begin
                        cmd.out_load = i_sts.last;
                        n_state      = S_IDLE;
                    end
                end
            end
            S_VAL: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_val  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign n_o_valid = cmd.out_load || (r_o_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    assign o_cmd   = cmd;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_o_valid;

    property p_cmd_excl;
        @(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clear, cmd.accept, cmd.resolve, cmd.out_val});
    endproperty
    a_cmd_excl: assert property (p_cmd_excl)
        else $error("more than one datapath step at once");

    property p_no_overwrite;
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> out_free;
    endproperty
    a_no_overwrite: assert property (p_no_overwrite)
        else $error("result register loaded over a pending word");

    property p_pending_held;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && i_stall) |=> r_o_valid;
    endproperty
    a_pending_held: assert property (p_pending_held)
        else $error("pending result word dropped");

    property p_accept_to_link;
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |=> (r_state == S_LINK);
    endproperty
    a_accept_to_link: assert property (p_accept_to_link)
        else $error("accepted word not followed by link resolve");

endmodule

// File: rtl/trie_insert_lookup_unit.sv
`timescale 1ns / 1ps
// steps: accept and link resolve per key character, plus a node value read for the last
//   character of a lookup; the result word shows in the cycle after the last step
// input: a new word is accepted only after the previous word's steps are done, since the child
//   link read must finish before the next node is known
// reset: synchronous, active low; a clearing pass over all NODES*SYMBOLS link slots (76800 by
//   default) then zeroes child links and stored-value marks while input is stalled
// ----------------------------------------------------------------------------
// trie insert/lookup unit
// character-serial prefix tree: lookup reports a stored value, insert
// allocates missing nodes and stores the value at the key's final node
// ----------------------------------------------------------------------------
module trie_insert_lookup_unit #(
    parameter int NODES      = tiu_pkg::NODES_DEF,
    parameter int SYMBOLS    = tiu_pkg::SYMBOLS_DEF,
    parameter int VALUE_BITS = tiu_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input word
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_mode,
    input  logic [7:0]            i_character,
    input  logic                  i_last,
    input  logic [VALUE_BITS-1:0] i_value,
    // result word
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [1:0]            o_status,
    output logic [VALUE_BITS-1:0] o_result_value
);

    import tiu_pkg::*;

    // command and status between controller and datapath
    t_cmd cmd;
    t_sts sts;

    // controller: clearing pass, then per word accept -> link resolve
    // (-> node value read for the last character of a lookup); the
    // result register lets a new word in while a result word waits
    tiu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall),
        .o_valid (o_valid)
    );

    // datapath: current node, first failure of the key, node pool count,
    // child link memory (one slot per node and symbol, zero means no child)
    // and node value memory with a stored-value mark per node
    tiu_dp #(
        .NODES      (NODES),
        .SYMBOLS    (SYMBOLS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_mode         (i_mode),
        .i_character    (i_character),
        .i_last         (i_last),
        .i_value        (i_value),
        .o_status       (o_status),
        .o_result_value (o_result_value)
    );

endmodule
